// ===== design/wbps_pkg.sv =====
// package for the wildcard byte pattern search block
// types, widths and register indexes; no dependencies

package wbps_pkg;

    // pattern and offset sizes
    localparam int PATTERN_MAX = 16;
    localparam int OFFSET_BITS = 32;
    localparam int LEN_BITS    = 5;
    localparam int HIT_BITS    = 16;
    localparam int CFG_BITS    = 64;
    localparam int CFG_IDX_BITS = 3;

    // result queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_LOW   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_HIGH  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CARE_MASK = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_LEN   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_HITS  = 3'd4;

    // result kinds
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // one result word
    typedef struct packed {
        logic                   kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [HIT_BITS-1:0]    hits;
        logic                   last;
    } t_result;

endpackage

// ===== design/wildcard_byte_pattern_search_top.sv =====
// A result word is written into the result queue when its byte is accepted.
// One byte per cycle while input ready is high; a byte that causes both a match
// and a done result pushes two words, buffered in a four-word result queue.
// Input ready drops when the queue has fewer than two free words.
// Reset (synchronous, active low) clears window, position, hit count, queue
// and sets the configuration registers to their reset values.
// depends on wbps_pkg

module wildcard_byte_pattern_search_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [wbps_pkg::CFG_BITS-1:0]     i_cfg_data,
    // byte channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_range_start,
    input  logic                              i_range_end,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_result_kind,
    output logic [wbps_pkg::OFFSET_BITS-1:0]  o_match_offset,
    output logic [wbps_pkg::HIT_BITS-1:0]     o_hit_total,
    output logic                              o_final_result
);
    import wbps_pkg::*;

    // configuration registers
    logic [CFG_BITS-1:0]    r_pat_low;
    logic [CFG_BITS-1:0]    r_pat_high;
    logic [PATTERN_MAX-1:0] r_care;
    logic [LEN_BITS-1:0]    r_pat_len;
    logic [HIT_BITS-1:0]    r_max_hits;

    // scan state
    logic [7:0]             r_window [PATTERN_MAX];
    logic [OFFSET_BITS-1:0] r_pos;
    logic [HIT_BITS-1:0]    r_hits;

    // result queue
    t_result                r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    logic                   in_acc;
    logic                   out_acc;
    logic [7:0]             n_window [PATTERN_MAX];
    logic [7:0]             pat_byte [PATTERN_MAX];
    logic [4:0]             age      [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] mismatch;
    logic [LEN_BITS-1:0]    len_eff;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [OFFSET_BITS-1:0] pos_base;
    logic [HIT_BITS-1:0]    hits_base;
    logic [HIT_BITS-1:0]    n_hits;
    logic                   hit;
    logic [1:0]             push_cnt;
    t_result                hit_res;
    t_result                done_res;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '0;
            r_pat_len  <= LEN_BITS'(1);
            r_max_hits <= HIT_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PAT_LOW:   r_pat_low  <= i_cfg_data;
                REG_PAT_HIGH:  r_pat_high <= i_cfg_data;
                REG_CARE_MASK: r_care     <= i_cfg_data[PATTERN_MAX-1:0];
                REG_PAT_LEN:   r_pat_len  <= i_cfg_data[LEN_BITS-1:0];
                REG_MAX_HITS:  r_max_hits <= i_cfg_data[HIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pattern bytes split out of the two words
    always_comb begin
        for (int k = 0; k < PATTERN_MAX / 2; k++) begin
            pat_byte[k]                   = r_pat_low[8*k +: 8];
            pat_byte[k + PATTERN_MAX / 2] = r_pat_high[8*k +: 8];
        end
    end

    // length clamp, new window and saturating position
    always_comb begin
        len_eff = (r_pat_len > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX) : r_pat_len;
        n_window[0] = i_data_byte;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            n_window[i] = r_window[i-1];
        end
        pos_base  = i_range_start ? '0 : r_pos;
        hits_base = i_range_start ? '0 : r_hits;
        n_pos     = (pos_base == '1) ? pos_base : pos_base + OFFSET_BITS'(1);
    end

    // parallel compare: pattern byte k against the byte received len-1-k ago
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            age[k]      = len_eff - 5'(k) - 5'd1;
            mismatch[k] = (5'(k) < len_eff) && r_care[k] &&
                          (n_window[age[k][3:0]] != pat_byte[k]);
        end
        hit = (len_eff != '0) && (n_pos >= OFFSET_BITS'(len_eff)) &&
              (hits_base < r_max_hits) && (mismatch == '0);
        n_hits = hit ? hits_base + HIT_BITS'(1) : hits_base;
    end

    // result words for this byte
    always_comb begin
        hit_res.kind    = KIND_MATCH;
        hit_res.offset  = n_pos - OFFSET_BITS'(len_eff);
        hit_res.hits    = n_hits;
        hit_res.last    = !i_range_end;
        done_res.kind   = KIND_DONE;
        done_res.offset = '0;
        done_res.hits   = n_hits;
        done_res.last   = 1'b1;
        push_cnt = in_acc ? (2'(hit) + 2'(i_range_end)) : 2'd0;
    end

    // scan state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_window[i] <= '0;
            end
            r_pos  <= '0;
            r_hits <= '0;
        end else if (in_acc) begin
            r_window <= n_window;
            r_pos    <= n_pos;
            r_hits   <= n_hits;
        end
    end

    // result queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(push_cnt);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(out_acc);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= hit ? hit_res : done_res;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_PTR_W'(1)] <= done_res;
        end
    end

    // handshake and output fields
    assign o_in_ready     = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_out_valid    = (r_count != '0);
    assign o_result_kind  = r_fifo[r_rd_ptr].kind;
    assign o_match_offset = r_fifo[r_rd_ptr].offset;
    assign o_hit_total    = r_fifo[r_rd_ptr].hits;
    assign o_final_result = r_fifo[r_rd_ptr].last;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count above depth");

    // a range end always leaves a word queued
    a_end_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_range_end |=> r_count != '0)
        else $error("range end produced no result");

    // a match word always counts itself
    a_match_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_MATCH |-> o_hit_total != '0)
        else $error("match result with zero hit total");

    // position only moves forward within a range
    a_pos_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_range_start |=> r_pos >= $past(r_pos))
        else $error("byte position went backward");

    // hits never exceed the limit after a match
    a_hit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && hit |=> r_hits <= r_max_hits)
        else $error("hit count above limit");

endmodule
